@@ sv/semi_lagrangian_trilinear_advect_top_assert.svh @@
// assertion macros for the advection block
`ifndef SEMI_LAGRANGIAN_TRILINEAR_ADVECT_TOP_ASSERT_SVH
`define SEMI_LAGRANGIAN_TRILINEAR_ADVECT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SLA_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// a signal holds its value in the cycle after the condition
`define SLA_ASSERT_STABLE(label, clk, rst_n, cond, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("value changed while held");
`else
`define SLA_ASSERT_IMPL(label, clk, rst_n, prop)
`define SLA_ASSERT_STABLE(label, clk, rst_n, cond, sig)
`endif
`endif

@@ sv/slta_pkg.sv @@
// ----------------------------------------------------------------------------
// slta_pkg
// constants and types shared by the advection block
// ----------------------------------------------------------------------------
package slta_pkg;
	localparam int unsigned FRAC_W = 16;
	localparam logic [16:0] FRAC_ONE = 17'h10000;

	// cells per axis held in the store
	localparam int MAX_DIM = 32;

	typedef enum logic [1:0] {
		REG_SIZE_X    = 2'd0,
		REG_SIZE_Y    = 2'd1,
		REG_SIZE_Z    = 2'd2,
		REG_TIME_STEP = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_ADVECT = 1'b1
	} action_t;

	// signed weighted blend, floor by 2^16; result lies between a and b
	function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic [15:0] f);
		logic signed [49:0] s;
		begin
			s = 50'(a) * $signed({1'b0, FRAC_ONE - 17'(f)}) + 50'(b) * $signed({17'b0, f});
			lerp = s[47:16];
		end
	endfunction
endpackage

@@ sv/semi_lagrangian_trilinear_advect_top.sv @@
// ----------------------------------------------------------------------------
// semi_lagrangian_trilinear_advect_top
// semi-Lagrangian advection of a scalar field with trilinear interpolation
// ----------------------------------------------------------------------------
// Takes one item per cycle while the output is not stalled; a stalled output
// holds the whole pipe and raises in_stall. An advect result passes through
// stages 1 to 5 into the output register; loads give no result.
// The field lies in eight synchronous memories banked by the parity of each
// index, so all eight corners of a cell are read together. The read address
// is formed in stage 2 and the data lands in stage 3; a load writes as it
// leaves stage 2, before any later item reads there, so no forwarding is needed.
// Contents are undefined until loaded.
module semi_lagrangian_trilinear_advect_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [23:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [4:0]                   cell_x,
	input  logic [4:0]                   cell_y,
	input  logic [4:0]                   cell_z,
	input  logic signed [31:0]           load_value,
	input  logic signed [23:0]           vel_u,
	input  logic signed [23:0]           vel_v,
	input  logic signed [23:0]           vel_w,
	input  logic                         solid,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [4:0]                   out_x,
	output logic [4:0]                   out_y,
	output logic [4:0]                   out_z,
	output logic signed [31:0]           new_value
);
	import slta_pkg::*;
	`include "semi_lagrangian_trilinear_advect_top_assert.svh"

	localparam int IW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int BD = (IW > 1) ? (1 << (3 * (IW - 1))) : 1;
	localparam int AW = (IW > 1) ? 3 * (IW - 1) : 1;
	localparam logic [8:0] MAXM1 = 9'(MAX_DIM - 1);

	// configuration registers
	logic [5:0] size_x_q, size_y_q, size_z_q;
	logic [23:0] time_step_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 6'd32;
			size_y_q <= 6'd32;
			size_z_q <= 6'd32;
			time_step_q <= 24'h010000;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SIZE_X:    size_x_q <= cfg_data[5:0];
				REG_SIZE_Y:    size_y_q <= cfg_data[5:0];
				REG_SIZE_Z:    size_z_q <= cfg_data[5:0];
				REG_TIME_STEP: time_step_q <= cfg_data;
			endcase
		end
	end

	// effective size minus one, as index top
	function automatic logic [8:0] top_of(input logic [5:0] s);
		logic [8:0] e;
		begin
			e = (s == 6'd0) ? 9'd1 : 9'(s);
			if (e > 9'(MAX_DIM)) e = 9'(MAX_DIM);
			top_of = e - 9'd1;
		end
	endfunction

	// pipeline advance: whole pipe stalls with the output register
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: displacement products
	logic v_s1, act_s1, solid_s1;
	logic [4:0] x_s1, y_s1, z_s1;
	logic signed [31:0] lv_s1;
	logic signed [48:0] px_s1, py_s1, pz_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= action; solid_s1 <= solid;
			x_s1 <= cell_x; y_s1 <= cell_y; z_s1 <= cell_z;
			lv_s1 <= load_value;
			px_s1 <= $signed({1'b0, time_step_q}) * 49'(vel_u);
			py_s1 <= $signed({1'b0, time_step_q}) * 49'(vel_v);
			pz_s1 <= $signed({1'b0, time_step_q}) * 49'(vel_w);
		end
	end

	// stage 2: trace back and clamp per axis
	function automatic logic [24:0] trace_pos(input logic [4:0] c,
		input logic signed [48:0] p, input logic [8:0] top);
		logic signed [34:0] pos;
		logic signed [34:0] tp;
		begin
			pos = $signed({14'b0, c, 16'b0}) - 35'($signed(p[48:16]));
			tp = $signed({10'b0, top, 16'b0});
			if (pos < 0) pos = '0;
			if (pos > tp) pos = tp;
			trace_pos = pos[24:0];
		end
	endfunction

	logic v_s2, act_s2, solid_s2;
	logic [4:0] x_s2, y_s2, z_s2;
	logic signed [31:0] lv_s2;
	logic [24:0] qx_s2, qy_s2, qz_s2;
	logic [8:0] tx_s2, ty_s2, tz_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s2 <= act_s1; solid_s2 <= solid_s1;
			x_s2 <= x_s1; y_s2 <= y_s1; z_s2 <= z_s1; lv_s2 <= lv_s1;
			tx_s2 <= top_of(size_x_q); ty_s2 <= top_of(size_y_q);
			tz_s2 <= top_of(size_z_q);
			qx_s2 <= trace_pos(x_s1, px_s1, top_of(size_x_q));
			qy_s2 <= trace_pos(y_s1, py_s1, top_of(size_y_q));
			qz_s2 <= trace_pos(z_s1, pz_s1, top_of(size_z_q));
		end
	end

	// stage 2 combinational: corner indices
	logic [8:0] i0, i1, j0, j1, k0, k1;
	always_comb begin
		if (solid_s2) begin
			i0 = (9'(x_s2) > MAXM1) ? MAXM1 : 9'(x_s2);
			j0 = (9'(y_s2) > MAXM1) ? MAXM1 : 9'(y_s2);
			k0 = (9'(z_s2) > MAXM1) ? MAXM1 : 9'(z_s2);
		end else begin
			i0 = qx_s2[24:16]; j0 = qy_s2[24:16]; k0 = qz_s2[24:16];
		end
		i1 = (i0 < tx_s2) ? i0 + 9'd1 : tx_s2;
		j1 = (j0 < ty_s2) ? j0 + 9'd1 : ty_s2;
		k1 = (k0 < tz_s2) ? k0 + 9'd1 : tz_s2;
		if (solid_s2) begin
			i1 = i0; j1 = j0; k1 = k0;
		end
	end

	// banked store: bank = parity bits, address = upper index bits
	logic signed [31:0] mem [8][BD];
	logic signed [31:0] rd_s3 [8];
	logic [AW-1:0] ra [8];
	logic [AW-1:0] wa;
	logic [2:0] wb;
	logic wr_ok;
	logic [IW-1:0] lx, ly, lz;
	assign lx = IW'(x_s2); assign ly = IW'(y_s2); assign lz = IW'(z_s2);
	assign wr_ok = adv && v_s2 && (act_s2 == ACT_LOAD) &&
		(9'(x_s2) <= MAXM1) && (9'(y_s2) <= MAXM1) && (9'(z_s2) <= MAXM1);
	assign wb = {lz[0], ly[0], lx[0]};
	function automatic logic [AW-1:0] bank_addr(input logic [IW-1:0] a,
		input logic [IW-1:0] b, input logic [IW-1:0] c);
		begin
			bank_addr = {c[IW-1:1], b[IW-1:1], a[IW-1:1]};
		end
	endfunction
	assign wa = bank_addr(lx, ly, lz);

	// per-bank corner address: the corner whose parity matches the bank
	logic [8:0] bx [8], by [8], bz [8];
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			bx[b] = (i0[0] == b[0]) ? i0 : i1;
			by[b] = (j0[0] == b[1]) ? j0 : j1;
			bz[b] = (k0[0] == b[2]) ? k0 : k1;
			ra[b] = bank_addr(IW'(bx[b]), IW'(by[b]), IW'(bz[b]));
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < 8; b++) begin
			if (wr_ok && wb == 3'(b)) mem[b][wa] <= lv_s2;
			if (adv) rd_s3[b] <= mem[b][ra[b]];
		end
	end

	// stage 3
	logic v_s3, solid_s3;
	logic [4:0] x_s3, y_s3, z_s3;
	logic [15:0] fx_s3, fy_s3, fz_s3;
	logic i0p_s3, j0p_s3, k0p_s3;
	logic i_same_s3, j_same_s3, k_same_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2 && (act_s2 == ACT_ADVECT);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			solid_s3 <= solid_s2;
			x_s3 <= x_s2; y_s3 <= y_s2; z_s3 <= z_s2;
			fx_s3 <= solid_s2 ? 16'd0 : qx_s2[15:0];
			fy_s3 <= solid_s2 ? 16'd0 : qy_s2[15:0];
			fz_s3 <= solid_s2 ? 16'd0 : qz_s2[15:0];
			i0p_s3 <= i0[0]; j0p_s3 <= j0[0]; k0p_s3 <= k0[0];
			i_same_s3 <= (i1 == i0); j_same_s3 <= (j1 == j0); k_same_s3 <= (k1 == k0);
		end
	end

	// corner c (bits z,y,x of 1-index choice) sits in bank parity^choice
	function automatic logic [2:0] bank_of(input logic [2:0] c,
		input logic px, input logic py, input logic pz);
		begin
			bank_of = c ^ {pz, py, px};
		end
	endfunction
	// where the upper index equals the lower one, the opposite-parity bank
	// holds a different cell, so both choices take the lower corner
	logic signed [31:0] cv [8];
	always_comb begin
		for (int c = 0; c < 8; c++)
			cv[c] = rd_s3[bank_of(3'(c) & ~{k_same_s3, j_same_s3, i_same_s3},
				i0p_s3, j0p_s3, k0p_s3)];
	end

	// stage 4: blend along z
	logic v_s4;
	logic [4:0] x_s4, y_s4, z_s4;
	logic [15:0] fx_s4, fy_s4;
	logic signed [31:0] a_s4 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4 <= x_s3; y_s4 <= y_s3; z_s4 <= z_s3;
			fx_s4 <= fx_s3; fy_s4 <= fy_s3;
			for (int q = 0; q < 4; q++)
				a_s4[q] <= lerp(cv[q[1:0]], cv[3'(q) | 3'd4], fz_s3);
		end
	end

	// stage 5: blend along y
	logic v_s5;
	logic [4:0] x_s5, y_s5, z_s5;
	logic [15:0] fx_s5;
	logic signed [31:0] b_s5 [2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s5 <= x_s4; y_s5 <= y_s4; z_s5 <= z_s4; fx_s5 <= fx_s4;
			b_s5[0] <= lerp(a_s4[0], a_s4[2], fy_s4);
			b_s5[1] <= lerp(a_s4[1], a_s4[3], fy_s4);
		end
	end

	// stage 6: blend along x into output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_x <= x_s5; out_y <= y_s5; out_z <= z_s5;
			new_value <= lerp(b_s5[0], b_s5[1], fx_s5);
		end
	end

	`SLA_ASSERT_IMPL(a_stall_hold, clk, arst_n, (out_valid && out_stall) |=> out_valid)
	`SLA_ASSERT_STABLE(a_stable_val, clk, arst_n, out_valid && out_stall, new_value)
	`SLA_ASSERT_IMPL(a_in_stall, clk, arst_n, in_stall |-> (out_valid && out_stall))
endmodule

@@ dv/semi_lagrangian_trilinear_advect_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// semi_lagrangian_trilinear_advect_top_tb
// self-checking bench for the semi-Lagrangian trilinear advection block
// ----------------------------------------------------------------------------
// Loads the field region in use for each grid setting, then sends directed
// and random load and advect items with bursty input and patterned output
// stalls. A behavioural predictor computes the traced, clamped and
// interpolated value of every advect item and each result is compared in order.
module semi_lagrangian_trilinear_advect_top_tb;
	import slta_pkg::*;

	localparam int DIM = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LATENCY = 7;

	typedef struct {
		action_t            act;
		logic [4:0]         x;
		logic [4:0]         y;
		logic [4:0]         z;
		logic signed [31:0] val;
		logic signed [23:0] u;
		logic signed [23:0] v;
		logic signed [23:0] w;
		logic               sld;
	} cell_item_t;

	typedef struct {
		logic [4:0]         x;
		logic [4:0]         y;
		logic [4:0]         z;
		logic signed [31:0] val;
	} advected_cell_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               action;
	logic [4:0]         cell_x;
	logic [4:0]         cell_y;
	logic [4:0]         cell_z;
	logic signed [31:0] load_value;
	logic signed [23:0] vel_u;
	logic signed [23:0] vel_v;
	logic signed [23:0] vel_w;
	logic               solid;
	logic               out_valid;
	logic               out_stall;
	logic [4:0]         out_x;
	logic [4:0]         out_y;
	logic [4:0]         out_z;
	logic signed [31:0] new_value;

	// shadow of the field store and of the registers
	logic signed [31:0] field_shadow [0:DIM*DIM*DIM-1];
	logic [5:0]         size_reg [0:2];
	logic [23:0]        step_reg;

	advected_cell_t     pending_cells [$];
	int                 mismatches;
	int                 advects_checked;
	int                 loads_sent;
	int                 settings_used;
	int                 cycles;
	int                 hold_left;
	bit                 rx_quiet;
	bit                 tx_gaps;
	int                 burst_left;
	logic [15:0]        stall_pat;
	int                 stall_phase;

	semi_lagrangian_trilinear_advect_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
		.load_value(load_value), .vel_u(vel_u), .vel_v(vel_v), .vel_w(vel_w),
		.solid(solid),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .new_value(new_value)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver stalls: long hold-off, quiet stretches or a rotating pattern
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left = hold_left - 1;
		end else if (rx_quiet) begin
			out_stall = 1'b0;
		end else begin
			out_stall = stall_pat[stall_phase];
			stall_phase = (stall_phase + 1) % 16;
			if (stall_phase == 0)
				stall_pat = 16'($urandom);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_cells.size() == 0) begin
				$display("%0t unexpected result x=%0d y=%0d z=%0d value=%0d",
					$time, out_x, out_y, out_z, new_value);
				mismatches++;
			end else begin
				advected_cell_t exp_cell;
				exp_cell = pending_cells.pop_front();
				advects_checked++;
				if (out_x !== exp_cell.x || out_y !== exp_cell.y || out_z !== exp_cell.z) begin
					$display("%0t cell mismatch: expected (%0d,%0d,%0d) actual (%0d,%0d,%0d)",
						$time, exp_cell.x, exp_cell.y, exp_cell.z, out_x, out_y, out_z);
					mismatches++;
				end
				if (new_value !== exp_cell.val) begin
					$display("%0t value mismatch at (%0d,%0d,%0d): expected %0d actual %0d",
						$time, exp_cell.x, exp_cell.y, exp_cell.z, exp_cell.val, new_value);
					mismatches++;
				end
			end
		end
	end

	function automatic int eff_size(input logic [5:0] r);
		if (r == 0)
			return 1;
		if (r > DIM)
			return DIM;
		return int'(r);
	endfunction

	function automatic int field_addr(input int x, input int y, input int z);
		return x + DIM * (y + DIM * z);
	endfunction

	// back-trace along one axis, clamped to the grid in use
	function automatic void trace_axis(input int c, input logic signed [23:0] vel,
		input int sz, output int lo, output int hi, output longint fr);
		longint disp;
		longint pos;
		longint top;
		disp = (longint'(step_reg) * longint'(vel)) >>> 16;
		pos = longint'(c) * 65536 - disp;
		top = longint'(sz - 1) * 65536;
		if (pos < 0)
			pos = 0;
		if (pos > top)
			pos = top;
		lo = int'(pos >>> 16);
		fr = pos & 64'hFFFF;
		hi = (lo + 1 < sz) ? lo + 1 : sz - 1;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint f);
		return (a * (65536 - f) + b * f) >>> 16;
	endfunction

	function automatic longint corner(input int x, input int y, input int z);
		return longint'(field_shadow[field_addr(x, y, z)]);
	endfunction

	function automatic logic signed [31:0] advect_value(input cell_item_t it);
		int i0, i1, j0, j1, k0, k1;
		longint fs, ft, fu;
		longint a00, a01, a10, a11, b0, b1;
		if (it.sld)
			return field_shadow[field_addr(it.x, it.y, it.z)];
		trace_axis(it.x, it.u, eff_size(size_reg[0]), i0, i1, fs);
		trace_axis(it.y, it.v, eff_size(size_reg[1]), j0, j1, ft);
		trace_axis(it.z, it.w, eff_size(size_reg[2]), k0, k1, fu);
		a00 = blend(corner(i0, j0, k0), corner(i0, j0, k1), fu);
		a01 = blend(corner(i0, j1, k0), corner(i0, j1, k1), fu);
		a10 = blend(corner(i1, j0, k0), corner(i1, j0, k1), fu);
		a11 = blend(corner(i1, j1, k0), corner(i1, j1, k1), fu);
		b0 = blend(a00, a01, ft);
		b1 = blend(a10, a11, ft);
		return 32'(blend(b0, b1, fs));
	endfunction

	// update the shadow for one accepted item
	function automatic void track_item(input cell_item_t it);
		advected_cell_t c;
		if (it.act == ACT_LOAD) begin
			field_shadow[field_addr(it.x, it.y, it.z)] = it.val;
			loads_sent++;
		end else begin
			c.x = it.x;
			c.y = it.y;
			c.z = it.z;
			c.val = advect_value(it);
			pending_cells.push_back(c);
		end
	endfunction

	// send one item, then maybe leave a gap
	task automatic send_item(input cell_item_t it);
		int gap;
		@(negedge clk);
		action = it.act;
		cell_x = it.x;
		cell_y = it.y;
		cell_z = it.z;
		load_value = it.val;
		vel_u = it.u;
		vel_v = it.v;
		vel_w = it.w;
		solid = it.sld;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_item(it);
		if (tx_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(0, 12);
				gap = $urandom_range(1, 6);
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_TIME_STEP)
			step_reg = data;
		else
			size_reg[idx] = data[5:0];
	endtask

	function automatic cell_item_t load_item(input int x, input int y, input int z,
		input logic signed [31:0] val);
		cell_item_t it;
		it.act = ACT_LOAD;
		it.x = 5'(x);
		it.y = 5'(y);
		it.z = 5'(z);
		it.val = val;
		it.u = 24'($urandom);
		it.v = 24'($urandom);
		it.w = 24'($urandom);
		it.sld = 1'($urandom);
		return it;
	endfunction

	function automatic cell_item_t advect_item(input int x, input int y, input int z,
		input logic signed [23:0] u, input logic signed [23:0] v,
		input logic signed [23:0] w, input logic sld);
		cell_item_t it;
		it.act = ACT_ADVECT;
		it.x = 5'(x);
		it.y = 5'(y);
		it.z = 5'(z);
		it.val = 32'($urandom);
		it.u = u;
		it.v = v;
		it.w = w;
		it.sld = sld;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic signed [23:0] rand_vel();
		case ($urandom_range(0, 5))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2, 3: return 24'($signed($urandom_range(0, 20'h7FFFF)) - 24'sh40000);
			default: return 24'($urandom);
		endcase
	endfunction

	// program a grid setting and fill the whole region in use
	task automatic set_grid(input logic [5:0] sx, input logic [5:0] sy,
		input logic [5:0] sz, input logic [23:0] step);
		wait_drain();
		write_reg(REG_SIZE_X, 24'(sx));
		write_reg(REG_SIZE_Y, 24'(sy));
		write_reg(REG_SIZE_Z, 24'(sz));
		write_reg(REG_TIME_STEP, step);
		settings_used++;
		for (int z = 0; z < eff_size(sz); z++)
			for (int y = 0; y < eff_size(sy); y++)
				for (int x = 0; x < eff_size(sx); x++)
					send_item(load_item(x, y, z, rand_value()));
	endtask

	// random cell inside the loaded region
	task automatic region_cell(output int x, output int y, output int z);
		x = $urandom_range(0, eff_size(size_reg[0]) - 1);
		y = $urandom_range(0, eff_size(size_reg[1]) - 1);
		z = $urandom_range(0, eff_size(size_reg[2]) - 1);
	endtask

	// one random item: loads anywhere, solid reads inside the region,
	// traced reads from any cell
	task automatic send_random_item();
		int x, y, z;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			if ($urandom_range(0, 1))
				region_cell(x, y, z);
			else begin
				x = $urandom_range(0, 31);
				y = $urandom_range(0, 31);
				z = $urandom_range(0, 31);
			end
			send_item(load_item(x, y, z, rand_value()));
		end else if (pick < 5) begin
			region_cell(x, y, z);
			send_item(advect_item(x, y, z, rand_vel(), rand_vel(), rand_vel(), 1'b1));
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				x = $urandom_range(0, 31);
				y = $urandom_range(0, 31);
				z = $urandom_range(0, 31);
			end else
				region_cell(x, y, z);
			send_item(advect_item(x, y, z, rand_vel(), rand_vel(), rand_vel(), 1'b0));
		end
	endtask

	// zero and the largest steps on a single cell; size 0 acts as 1
	task automatic test_single_cell();
		set_grid(6'd0, 6'd1, 6'd0, 24'd0);
		send_item(advect_item(0, 0, 0, 24'h7F_FFFF, 24'h80_0000, 24'd0, 1'b0));
		send_item(advect_item(31, 31, 31, 24'd0, 24'd0, 24'd0, 1'b0));
		send_item(advect_item(0, 0, 0, 24'h12_3456, 24'd0, 24'd0, 1'b1));
		set_grid(6'd1, 6'd0, 6'd1, 24'hFF_FFFF);
		send_item(advect_item(17, 5, 10, 24'h80_0000, 24'h7F_FFFF, 24'h00_0001, 1'b0));
	endtask

	// small box: fractions, clamping both ways, cell beyond size, solid
	task automatic test_small_box();
		set_grid(6'd4, 6'd3, 6'd2, 24'h01_0000);
		send_item(load_item(1, 1, 1, 32'h7FFF_FFFF));
		send_item(load_item(2, 1, 1, 32'h8000_0000));
		send_item(load_item(1, 2, 0, 32'h0000_0000));
		send_item(advect_item(2, 1, 1, 24'h00_8000, 24'd0, 24'd0, 1'b0));
		send_item(advect_item(2, 2, 1, 24'h00_4000, 24'h00_C000, 24'h00_2000, 1'b0));
		send_item(advect_item(0, 0, 0, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 1'b0));
		send_item(advect_item(3, 2, 1, 24'h80_0000, 24'h80_0000, 24'h80_0000, 1'b0));
		send_item(advect_item(31, 31, 31, 24'h00_0001, 24'hFF_FFFF, 24'd0, 1'b0));
		send_item(advect_item(1, 1, 1, 24'd0, 24'd0, 24'd0, 1'b1));
		send_item(advect_item(2, 1, 1, 24'h7F_FFFF, 24'd0, 24'd0, 1'b1));
		// load then read the same cell in consecutive items
		send_item(load_item(3, 2, 1, 32'h1234_5678));
		send_item(advect_item(3, 2, 1, 24'd0, 24'd0, 24'd0, 1'b1));
	endtask

	// each axis at full length, with the largest step on x; above-range sizes clamp
	task automatic test_long_axes();
		set_grid(6'd63, 6'd1, 6'd1, 24'hFF_FFFF);
		send_item(advect_item(31, 0, 0, 24'h00_0001, 24'd0, 24'd0, 1'b0));
		send_item(advect_item(0, 0, 0, 24'hFF_FFFF, 24'd0, 24'd0, 1'b0));
		send_item(advect_item(31, 0, 0, 24'd0, 24'd0, 24'd0, 1'b1));
		set_grid(6'd1, 6'd33, 6'd1, 24'h00_0001);
		send_item(advect_item(0, 31, 0, 24'd0, 24'h7F_FFFF, 24'd0, 1'b0));
		send_item(advect_item(0, 16, 0, 24'd0, 24'hFF_FFFF, 24'd0, 1'b0));
		set_grid(6'd2, 6'd1, 6'd32, 24'h00_8000);
		send_item(advect_item(1, 0, 31, 24'hFF_0000, 24'd0, 24'h03_0000, 1'b0));
		send_item(advect_item(0, 0, 15, 24'd0, 24'd0, 24'hFF_4000, 1'b0));
	endtask

	// random items over random grid settings
	task automatic test_random_grids();
		logic [5:0] s [0:2];
		logic [23:0] step;
		for (int p = 0; p < 6; p++) begin
			for (int a = 0; a < 3; a++)
				s[a] = 6'($urandom_range(0, 4));
			if (p == 2) begin
				for (int a = 0; a < 3; a++)
					s[a] = 6'($urandom_range(0, 1));
				s[$urandom_range(0, 2)] = 6'($urandom_range(32, 63));
			end
			case ($urandom_range(0, 3))
				0: step = 24'd0;
				1: step = 24'hFF_FFFF;
				default: step = 24'($urandom_range(0, 24'h04_0000));
			endcase
			tx_gaps = (p % 3) != 1;
			rx_quiet = (p % 3) == 2;
			set_grid(s[0], s[1], s[2], step);
			repeat (50) send_random_item();
		end
		tx_gaps = 1'b1;
		rx_quiet = 1'b0;
	endtask

	// long receiver hold-off while the sender keeps offering items
	task automatic test_backpressure();
		set_grid(6'd3, 6'd3, 6'd3, 24'h01_8000);
		tx_gaps = 1'b0;
		hold_left = 300;
		repeat (60) send_random_item();
		tx_gaps = 1'b1;
		wait_drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SIZE_X;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_LOAD;
		cell_x = '0;
		cell_y = '0;
		cell_z = '0;
		load_value = '0;
		vel_u = '0;
		vel_v = '0;
		vel_w = '0;
		solid = 1'b0;
		out_stall = 1'b0;
		mismatches = 0;
		advects_checked = 0;
		loads_sent = 0;
		settings_used = 0;
		cycles = 0;
		hold_left = 0;
		rx_quiet = 1'b0;
		tx_gaps = 1'b1;
		burst_left = 0;
		stall_pat = 16'h0F35;
		stall_phase = 0;
		size_reg[0] = 6'd32;
		size_reg[1] = 6'd32;
		size_reg[2] = 6'd32;
		step_reg = 24'h01_0000;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_cell();
		test_small_box();
		test_long_axes();
		test_backpressure();
		test_random_grids();

		wait_drain();
		$display("covered %0d grid settings, %0d loads and %0d checked advect results",
			settings_used, loads_sent, advects_checked);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/slta_pkg.sv
sv/semi_lagrangian_trilinear_advect_top.sv
dv/semi_lagrangian_trilinear_advect_top_tb.sv
